/* sv/jrd_pkg.sv */
// Shared constants, register codes and table-building functions for the Jansen-Rit derivative unit.
package jrd_pkg;

    localparam int MUL_LAT = 3;
    localparam int SIG_LAT = 13;

    localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;
    localparam logic [63:0] LN2_Q31 = 64'h0000_0000_58B9_0BFC;

    typedef enum logic [2:0] {
        REG_EXC_GAIN       = 3'd0,
        REG_INH_GAIN       = 3'd1,
        REG_EXC_RATE_CONST = 3'd2,
        REG_INH_RATE_CONST = 3'd3,
        REG_MAX_FIRE_RATE  = 3'd4,
        REG_HALF_POINT     = 3'd5,
        REG_STEEPNESS      = 3'd6,
        REG_CONNECTIVITY   = 3'd7
    } reg_index_t;

    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] logistic_entry(input int unsigned idx,
                                                   input int unsigned depth,
                                                   input int unsigned frac);
        logic [63:0] span;
        logic [63:0] eight;
        logic [63:0] pt;
        logic [63:0] mag;
        logic [63:0] a31;
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] numr;
        longint u;
        longint sum;
        span = 64'd16 << frac;
        eight = 64'd8 << frac;
        pt = udiv(span * 64'(idx), 64'(depth - 1));
        u = longint'(pt) - longint'(eight);
        mag = (u < 0) ? 64'(-u) : 64'(u);
        a31 = (frac <= 31) ? (mag << (31 - frac)) : (mag >> (frac - 31));
        k = '0;
        r = a31;
        for (int j = 0; j < 64; j++) begin
            if (r >= LN2_Q31) begin
                r = r - LN2_Q31;
                k = k + 64'd1;
            end
        end
        term = Q31_ONE;
        sum = longint'(Q31_ONE);
        for (int n = 1; n <= 12; n++) begin
            term = udiv((term * r) >> 31, 64'(n));
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        e = (k > 64'd40) ? 64'd0 : (64'(sum) >> k);
        den = Q31_ONE + e;
        numr = (u < 0) ? e : Q31_ONE;
        return udiv((numr << frac) + (den >> 1), den);
    endfunction

endpackage

/* sv/jrd_delay.sv */
// Enabled shift-register delay line that keeps side values aligned with the pipeline.
module jrd_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[N-1];

endmodule

/* sv/jrd_mul.sv */
// Three-stage fixed-point multiplier: floor of the scaled product, saturated to 40 bits.
module jrd_mul #(
    parameter int FRAC = 24
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [40:0] a,
    input  logic signed [40:0] b,
    output logic signed [39:0] p
);

    localparam int PW = 82;
    localparam logic [PW-1:0] RND = {{(PW-FRAC){1'b0}}, {FRAC{1'b1}}};
    localparam logic [PW-1:0] LIM_POS = PW'(40'h7F_FFFF_FFFF);
    localparam logic [PW-1:0] LIM_NEG = PW'(40'h80_0000_0000);

    logic [40:0] a_mag;
    logic [40:0] b_mag;
    logic [41:0] ll_next, ll_reg;
    logic [40:0] lh_next, lh_reg;
    logic [40:0] hl_next, hl_reg;
    logic [39:0] hh_next, hh_reg;
    logic        neg1_reg, neg2_reg;
    logic [PW-1:0] sum_next, sum_reg;
    logic [PW-1:0] q;
    logic [PW-1:0] lim;
    logic [39:0] qm;
    logic [39:0] p_next, p_reg;

    always_comb
    begin
        a_mag = a[40] ? (~a + 41'd1) : a;
        b_mag = b[40] ? (~b + 41'd1) : b;
        ll_next = 42'(a_mag[20:0]) * 42'(b_mag[20:0]);
        lh_next = 41'(a_mag[20:0]) * 41'(b_mag[40:21]);
        hl_next = 41'(a_mag[40:21]) * 41'(b_mag[20:0]);
        hh_next = 40'(a_mag[40:21]) * 40'(b_mag[40:21]);
    end

    always_comb
    begin
        sum_next = PW'(ll_reg) + (PW'(lh_reg) << 21) + (PW'(hl_reg) << 21)
                 + (PW'(hh_reg) << 42) + (neg1_reg ? RND : '0);
    end

    always_comb
    begin
        q = sum_reg >> FRAC;
        lim = neg2_reg ? LIM_NEG : LIM_POS;
        qm = (q > lim) ? lim[39:0] : q[39:0];
        p_next = neg2_reg ? (~qm + 40'd1) : qm;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg   <= ll_next;
            lh_reg   <= lh_next;
            hl_reg   <= hl_next;
            hh_reg   <= hh_next;
            neg1_reg <= a[40] ^ b[40];
            sum_reg  <= sum_next;
            neg2_reg <= neg1_reg;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* sv/jrd_sigmoid.sv */
// Pipelined sigmoid: slope product, clamp, table lookup, linear interpolation, rate scaling.
module jrd_sigmoid #(
    parameter int DEPTH = 256,
    parameter int FRAC  = 24
) (
    input  logic               clk,
    input  logic               en,
    input  logic        [38:0] steep,
    input  logic        [38:0] rmax,
    input  logic signed [40:0] diff,
    output logic signed [39:0] s
);

    localparam int IW  = $clog2(DEPTH);
    localparam int TW  = FRAC + 2;
    localparam int TPW = FRAC + 5;
    localparam int PW  = TPW + IW;
    localparam logic signed [39:0] EIGHT = 40'sd1 <<< (FRAC + 3);

    logic signed [TW-1:0] tab [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_tab
        localparam logic [63:0] ENTRY = jrd_pkg::logistic_entry(g, DEPTH, FRAC);
        assign tab[g] = TW'(ENTRY);
    end

    logic signed [39:0] w;
    logic signed [39:0] wc;
    logic [TPW-1:0] t_next, t_reg;
    logic [PW-1:0] prod;
    logic [PW-1:0] pos;
    logic [IW-1:0] idx_reg;
    logic [FRAC-1:0] fr_reg, fr2_reg;
    logic last_reg, last2_reg;
    logic [IW-1:0] hi_idx;
    logic signed [TW-1:0] lo_reg, dif_reg;
    logic signed [TW-1:0] lo_d;
    logic [0:0] last_d;
    logic signed [39:0] ip;
    logic signed [40:0] l_next, l_reg;

    jrd_mul #(.FRAC(FRAC)) u_slope (
        .clk (clk),
        .en  (en),
        .a   ({2'b00, steep}),
        .b   (diff),
        .p   (w)
    );

    always_comb
    begin
        wc = w;
        if (w > EIGHT)
        begin
            wc = EIGHT;
        end
        else if (w < -EIGHT)
        begin
            wc = -EIGHT;
        end
        t_next = TPW'(wc + EIGHT);
    end

    always_comb
    begin
        prod = PW'(t_reg) * PW'(DEPTH - 1);
        pos = prod >> 4;
        hi_idx = last_reg ? idx_reg : idx_reg + IW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= t_next;
            idx_reg   <= pos[FRAC +: IW];
            fr_reg    <= pos[FRAC-1:0];
            last_reg  <= (pos[FRAC +: IW] == IW'(DEPTH - 1));
            lo_reg    <= tab[idx_reg];
            dif_reg   <= tab[hi_idx] - tab[idx_reg];
            fr2_reg   <= fr_reg;
            last2_reg <= last_reg;
            l_reg     <= l_next;
        end
    end

    jrd_mul #(.FRAC(FRAC)) u_interp (
        .clk (clk),
        .en  (en),
        .a   (41'(dif_reg)),
        .b   (41'(fr2_reg)),
        .p   (ip)
    );

    jrd_delay #(.W(TW), .N(jrd_pkg::MUL_LAT)) u_lo_dly (
        .clk (clk),
        .en  (en),
        .d   (lo_reg),
        .q   (lo_d)
    );

    jrd_delay #(.W(1), .N(jrd_pkg::MUL_LAT)) u_last_dly (
        .clk (clk),
        .en  (en),
        .d   (last2_reg),
        .q   (last_d)
    );

    always_comb
    begin
        l_next = last_d[0] ? 41'(lo_d) : (41'(lo_d) + 41'(ip));
    end

    jrd_mul #(.FRAC(FRAC)) u_scale (
        .clk (clk),
        .en  (en),
        .a   ({2'b00, rmax}),
        .b   (l_reg),
        .p   (s)
    );

endmodule

/* sv/jansen_rit_derivative_top.sv */
// Jansen-Rit derivative unit: config registers, constant products and the main pipeline.
// One item per cycle is accepted while item_stall is low; the depth is set by the chain of three multiplier
// levels around the sigmoid pipeline. A held result freezes the whole pipeline.
// Reset clears all valid bits and loads the default register values; after reset or a
// register write the input is stalled while the register products settle.
module jansen_rit_derivative_top #(
    parameter int SIGMOID_TABLE_DEPTH = 256,
    parameter int FRACTION_BITS       = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [38:0] cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [39:0] pyr_potential,
    input  logic signed [39:0] exc_potential,
    input  logic signed [39:0] inh_potential,
    input  logic signed [39:0] pyr_aux,
    input  logic signed [39:0] exc_aux,
    input  logic signed [39:0] inh_aux,
    input  logic signed [39:0] external_drive,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [39:0] d_pyr_potential,
    output logic signed [39:0] d_exc_potential,
    output logic signed [39:0] d_inh_potential,
    output logic signed [39:0] d_pyr_aux,
    output logic signed [39:0] d_exc_aux,
    output logic signed [39:0] d_inh_aux,
    output logic signed [39:0] eeg_value
);

    localparam int ML     = jrd_pkg::MUL_LAT;
    localparam int S_VE   = ML;
    localparam int S_DIFF = S_VE + 1;
    localparam int S_SIG  = S_DIFF + jrd_pkg::SIG_LAT;
    localparam int S_M1   = S_SIG + ML;
    localparam int S_E4   = S_M1 + 1;
    localparam int S_M5   = S_M1 + ML;
    localparam int S_M4   = S_E4 + ML;
    localparam int S_OUT  = S_M4 + 1;

    localparam logic [40:0] K08 = 41'(((64'd4 << FRACTION_BITS) + 64'd2) / 64'd5);
    localparam logic signed [42:0] SAT_HI = 43'sd549755813887;
    localparam logic signed [42:0] SAT_LO = -43'sd549755813888;

    function automatic logic signed [39:0] sat40(input logic signed [42:0] x);
        logic signed [42:0] y;
        y = x;
        if (x > SAT_HI)
        begin
            y = SAT_HI;
        end
        else if (x < SAT_LO)
        begin
            y = SAT_LO;
        end
        return y[39:0];
    endfunction

    logic [38:0] he_reg, hi_reg, ke_reg, ki_reg, rmax_reg, v0_reg, steep_reg, conn_reg;
    logic [40:0] c_ext, cinh_ext, ke_ext, ki_ext;
    logic signed [39:0] hek, hik, kee, kii, cexc;
    logic [1:0] settle_reg, settle_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            he_reg    <= 39'd54525952;
            hi_reg    <= 39'd369098752;
            ke_reg    <= 39'd1677722;
            ki_reg    <= 39'd838861;
            rmax_reg  <= 39'd83886;
            v0_reg    <= 39'd100663296;
            steep_reg <= 39'd9395241;
            conn_reg  <= 39'd2264924160;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                jrd_pkg::REG_EXC_GAIN:       he_reg    <= cfg_data;
                jrd_pkg::REG_INH_GAIN:       hi_reg    <= cfg_data;
                jrd_pkg::REG_EXC_RATE_CONST: ke_reg    <= cfg_data;
                jrd_pkg::REG_INH_RATE_CONST: ki_reg    <= cfg_data;
                jrd_pkg::REG_MAX_FIRE_RATE:  rmax_reg  <= cfg_data;
                jrd_pkg::REG_HALF_POINT:     v0_reg    <= cfg_data;
                jrd_pkg::REG_STEEPNESS:      steep_reg <= cfg_data;
                jrd_pkg::REG_CONNECTIVITY:   conn_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_valid && cfg_ready)
        begin
            settle_next = 2'(ML);
        end
        else if (settle_reg != 2'd0)
        begin
            settle_next = settle_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= 2'(ML);
        end
        else
        begin
            settle_reg <= settle_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign c_ext     = {2'b00, conn_reg};
    assign cinh_ext  = {4'b0000, conn_reg[38:2]};
    assign ke_ext    = {2'b00, ke_reg};
    assign ki_ext    = {2'b00, ki_reg};

    // Products of registers only; these run freely and settle after a register write.
    jrd_mul #(.FRAC(FRACTION_BITS)) u_hek (.clk(clk), .en(1'b1),
        .a({2'b00, he_reg}), .b(ke_ext), .p(hek));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_hik (.clk(clk), .en(1'b1),
        .a({2'b00, hi_reg}), .b(ki_ext), .p(hik));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_kee (.clk(clk), .en(1'b1),
        .a(ke_ext), .b(ke_ext), .p(kee));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_kii (.clk(clk), .en(1'b1),
        .a(ki_ext), .b(ki_ext), .p(kii));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_cexc (.clk(clk), .en(1'b1),
        .a(K08), .b(c_ext), .p(cexc));

    logic en;
    logic [S_OUT:0] vld_reg;

    assign en = !(vld_reg[S_OUT] && result_stall);
    assign item_stall = !en || (settle_reg != 2'd0);
    assign result_valid = vld_reg[S_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[S_OUT-1:0], item_valid && (settle_reg == 2'd0)};
        end
    end

    logic signed [39:0] x0_reg, x1_reg, x2_reg, x3_reg, x4_reg, x5_reg, drv_reg;
    logic signed [39:0] vp_next, vp_reg;
    logic signed [40:0] dp_next, dp_reg;

    assign vp_next = sat40(43'(x1_reg) - 43'(x2_reg));
    assign dp_next = 41'(vp_reg) - 41'(v0_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg  <= pyr_potential;
            x1_reg  <= exc_potential;
            x2_reg  <= inh_potential;
            x3_reg  <= pyr_aux;
            x4_reg  <= exc_aux;
            x5_reg  <= inh_aux;
            drv_reg <= external_drive;
            vp_reg  <= vp_next;
            dp_reg  <= dp_next;
        end
    end

    logic signed [39:0] ve, vi, a3, a4, a5, b3, b4, b5;

    jrd_mul #(.FRAC(FRACTION_BITS)) u_ve (.clk(clk), .en(en),
        .a(c_ext), .b(41'(x0_reg)), .p(ve));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_vi (.clk(clk), .en(en),
        .a(cinh_ext), .b(41'(x0_reg)), .p(vi));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_a3 (.clk(clk), .en(en),
        .a(ke_ext), .b(41'(x3_reg)), .p(a3));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_a4 (.clk(clk), .en(en),
        .a(ke_ext), .b(41'(x4_reg)), .p(a4));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_a5 (.clk(clk), .en(en),
        .a(ki_ext), .b(41'(x5_reg)), .p(a5));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_b3 (.clk(clk), .en(en),
        .a(41'(kee)), .b(41'(x0_reg)), .p(b3));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_b4 (.clk(clk), .en(en),
        .a(41'(kee)), .b(41'(x1_reg)), .p(b4));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_b5 (.clk(clk), .en(en),
        .a(41'(kii)), .b(41'(x2_reg)), .p(b5));

    logic signed [40:0] de_reg, di_reg, dp_d;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            de_reg <= 41'(ve) - 41'(v0_reg);
            di_reg <= 41'(vi) - 41'(v0_reg);
        end
    end

    jrd_delay #(.W(41), .N(S_DIFF - 2)) u_dp_dly (.clk(clk), .en(en), .d(dp_reg), .q(dp_d));

    logic signed [39:0] sp, se, si;

    jrd_sigmoid #(.DEPTH(SIGMOID_TABLE_DEPTH), .FRAC(FRACTION_BITS)) u_sig_p (
        .clk(clk), .en(en), .steep(steep_reg), .rmax(rmax_reg), .diff(dp_d), .s(sp));
    jrd_sigmoid #(.DEPTH(SIGMOID_TABLE_DEPTH), .FRAC(FRACTION_BITS)) u_sig_e (
        .clk(clk), .en(en), .steep(steep_reg), .rmax(rmax_reg), .diff(de_reg), .s(se));
    jrd_sigmoid #(.DEPTH(SIGMOID_TABLE_DEPTH), .FRAC(FRACTION_BITS)) u_sig_i (
        .clk(clk), .en(en), .steep(steep_reg), .rmax(rmax_reg), .diff(di_reg), .s(si));

    logic signed [39:0] m3, ce, ci, m4, m5, drv_d;
    logic signed [39:0] e4_reg;

    jrd_mul #(.FRAC(FRACTION_BITS)) u_m3 (.clk(clk), .en(en),
        .a(41'(hek)), .b(41'(sp)), .p(m3));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_ce (.clk(clk), .en(en),
        .a(41'(cexc)), .b(41'(se)), .p(ce));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_ci (.clk(clk), .en(en),
        .a(cinh_ext), .b(41'(si)), .p(ci));

    jrd_delay #(.W(40), .N(S_M1)) u_drv_dly (.clk(clk), .en(en), .d(drv_reg), .q(drv_d));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e4_reg <= sat40(43'(drv_d) + 43'(ce));
        end
    end

    jrd_mul #(.FRAC(FRACTION_BITS)) u_m4 (.clk(clk), .en(en),
        .a(41'(hek)), .b(41'(e4_reg)), .p(m4));
    jrd_mul #(.FRAC(FRACTION_BITS)) u_m5 (.clk(clk), .en(en),
        .a(41'(hik)), .b(41'(ci)), .p(m5));

    logic signed [39:0] m3_d, m5_d, a3_d, a4_d, a5_d, b3_d, b4_d, b5_d;
    logic signed [39:0] x3_d, x4_d, x5_d, vp_d;

    jrd_delay #(.W(40), .N(S_M4 - S_M1)) u_m3_dly (.clk(clk), .en(en), .d(m3), .q(m3_d));
    jrd_delay #(.W(40), .N(S_M4 - S_M5)) u_m5_dly (.clk(clk), .en(en), .d(m5), .q(m5_d));
    jrd_delay #(.W(40), .N(S_M4 - S_VE)) u_a3_dly (.clk(clk), .en(en), .d(a3), .q(a3_d));
    jrd_delay #(.W(40), .N(S_M4 - S_VE)) u_a4_dly (.clk(clk), .en(en), .d(a4), .q(a4_d));
    jrd_delay #(.W(40), .N(S_M4 - S_VE)) u_a5_dly (.clk(clk), .en(en), .d(a5), .q(a5_d));
    jrd_delay #(.W(40), .N(S_M4 - S_VE)) u_b3_dly (.clk(clk), .en(en), .d(b3), .q(b3_d));
    jrd_delay #(.W(40), .N(S_M4 - S_VE)) u_b4_dly (.clk(clk), .en(en), .d(b4), .q(b4_d));
    jrd_delay #(.W(40), .N(S_M4 - S_VE)) u_b5_dly (.clk(clk), .en(en), .d(b5), .q(b5_d));
    jrd_delay #(.W(40), .N(S_OUT)) u_x3_dly (.clk(clk), .en(en), .d(x3_reg), .q(x3_d));
    jrd_delay #(.W(40), .N(S_OUT)) u_x4_dly (.clk(clk), .en(en), .d(x4_reg), .q(x4_d));
    jrd_delay #(.W(40), .N(S_OUT)) u_x5_dly (.clk(clk), .en(en), .d(x5_reg), .q(x5_d));
    jrd_delay #(.W(40), .N(S_OUT - 1)) u_vp_dly (.clk(clk), .en(en), .d(vp_reg), .q(vp_d));

    logic signed [39:0] d3_reg, d4_reg, d5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_reg <= sat40(43'(m3_d) - (43'(a3_d) <<< 1) - 43'(b3_d));
            d4_reg <= sat40(43'(m4) - (43'(a4_d) <<< 1) - 43'(b4_d));
            d5_reg <= sat40(43'(m5_d) - (43'(a5_d) <<< 1) - 43'(b5_d));
        end
    end

    assign d_pyr_potential = x3_d;
    assign d_exc_potential = x4_d;
    assign d_inh_potential = x5_d;
    assign d_pyr_aux       = d3_reg;
    assign d_exc_aux       = d4_reg;
    assign d_inh_aux       = d5_reg;
    assign eeg_value       = vp_d;

endmodule

/* tb/tb.sv */
// Self-checking testbench for jansen_rit_derivative_top: item stimulus, fixed-point predictor, result checks.
`timescale 1ns / 1ps

module tb;

    localparam int FB = 24;
    localparam int DEPTH = 256;
    localparam longint POS_MAX = (longint'(1) <<< 39) - 1;
    localparam longint NEG_MAX = -(longint'(1) <<< 39);
    localparam longint EIGHT = longint'(8) <<< FB;
    localparam longint ONE = longint'(1) <<< FB;
    localparam logic [63:0] Q31 = 64'h8000_0000;
    localparam logic [63:0] LN2 = 64'h58B9_0BFC;
    localparam int LIMIT = 600000;
    localparam int DRAIN = 40;
    localparam longint REG_RESET [8] = '{64'd54525952, 64'd369098752, 64'd1677722,
                                         64'd838861, 64'd83886, 64'd100663296,
                                         64'd9395241, 64'd2264924160};

    typedef struct {
        longint x0, x1, x2, x3, x4, x5, drive;
        bit has_eeg;
        longint eeg;
    } state_row_t;

    typedef struct {
        longint f[7];
    } deriv_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    jrd_pkg::reg_index_t cfg_index;
    logic [38:0] cfg_data;
    logic item_valid;
    logic item_stall;
    logic signed [39:0] pyr_potential, exc_potential, inh_potential;
    logic signed [39:0] pyr_aux, exc_aux, inh_aux, external_drive;
    logic result_valid;
    logic result_stall;
    logic signed [39:0] d_pyr_potential, d_exc_potential, d_inh_potential;
    logic signed [39:0] d_pyr_aux, d_exc_aux, d_inh_aux, eeg_value;

    longint cfg_copy[8];
    longint logistic_tab[DEPTH];
    deriv_t deriv_q[$];
    int err_cnt = 0;
    int items_in = 0;
    int results_out = 0;
    int cycles = 0;
    int stall_left = 0;
    bit stall_lvl = 0;
    bit row_has_eeg = 0;
    longint row_eeg = 0;

    jansen_rit_derivative_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid), .item_stall(item_stall),
        .pyr_potential(pyr_potential), .exc_potential(exc_potential),
        .inh_potential(inh_potential), .pyr_aux(pyr_aux), .exc_aux(exc_aux),
        .inh_aux(inh_aux), .external_drive(external_drive),
        .result_valid(result_valid), .result_stall(result_stall),
        .d_pyr_potential(d_pyr_potential), .d_exc_potential(d_exc_potential),
        .d_inh_potential(d_inh_potential), .d_pyr_aux(d_pyr_aux),
        .d_exc_aux(d_exc_aux), .d_inh_aux(d_inh_aux), .eeg_value(eeg_value)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint sat40(longint x);
        if (x > POS_MAX) return POS_MAX;
        if (x < NEG_MAX) return NEG_MAX;
        return x;
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> FB;
        if (p > POS_MAX) return POS_MAX;
        if (p < NEG_MAX) return NEG_MAX;
        return longint'(p);
    endfunction

    function automatic logic [63:0] exp_neg(logic [63:0] a);
        logic [63:0] a31, k, r, term;
        longint sum;
        a31 = a << (31 - FB);
        k = a31 / LN2;
        r = a31 - k * LN2;
        term = Q31;
        sum = longint'(Q31);
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * r) >> 31) / 64'(n);
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (k > 40) return 64'd0;
        return 64'(sum) >> k;
    endfunction

    function automatic void build_logistic();
        logic [63:0] e, den, num;
        longint u;
        for (int i = 0; i < DEPTH; i++)
        begin
            u = longint'(((64'd16 << FB) * 64'(i)) / 64'(DEPTH - 1)) - EIGHT;
            e = exp_neg((u < 0) ? 64'(-u) : 64'(u));
            den = Q31 + e;
            num = (u < 0) ? e : Q31;
            logistic_tab[i] = longint'(((num << FB) + (den >> 1)) / den);
        end
    endfunction

    function automatic longint fire_rate(longint v);
        longint w, l;
        logic [63:0] pos, idx, frac;
        w = fix_mul(cfg_copy[jrd_pkg::REG_STEEPNESS], v - cfg_copy[jrd_pkg::REG_HALF_POINT]);
        if (w > EIGHT) w = EIGHT;
        if (w < -EIGHT) w = -EIGHT;
        pos = (64'(w + EIGHT) * 64'(DEPTH - 1)) >> 4;
        idx = pos >> FB;
        frac = pos & ((64'd1 << FB) - 1);
        if (idx >= DEPTH - 1)
            l = logistic_tab[DEPTH - 1];
        else
            l = logistic_tab[idx] + fix_mul(logistic_tab[idx + 1] - logistic_tab[idx],
                                            longint'(frac));
        return fix_mul(cfg_copy[jrd_pkg::REG_MAX_FIRE_RATE], l);
    endfunction

    function automatic deriv_t predict_derivs(longint x0, longint x1, longint x2,
                                              longint x3, longint x4, longint x5,
                                              longint drive);
        deriv_t d;
        longint ke, ki, c, hek, hik, kee, kii, c_exc, c_inh, vp, sp, se, si;
        ke = cfg_copy[jrd_pkg::REG_EXC_RATE_CONST];
        ki = cfg_copy[jrd_pkg::REG_INH_RATE_CONST];
        c = cfg_copy[jrd_pkg::REG_CONNECTIVITY];
        hek = fix_mul(cfg_copy[jrd_pkg::REG_EXC_GAIN], ke);
        hik = fix_mul(cfg_copy[jrd_pkg::REG_INH_GAIN], ki);
        kee = fix_mul(ke, ke);
        kii = fix_mul(ki, ki);
        c_exc = fix_mul(((longint'(4) <<< FB) + 2) / 5, c);
        c_inh = c >>> 2;
        vp = sat40(x1 - x2);
        sp = fire_rate(vp);
        se = fire_rate(fix_mul(c, x0));
        si = fire_rate(fix_mul(c_inh, x0));
        d.f[0] = x3;
        d.f[1] = x4;
        d.f[2] = x5;
        d.f[3] = sat40(fix_mul(hek, sp) - 2 * fix_mul(ke, x3) - fix_mul(kee, x0));
        d.f[4] = sat40(fix_mul(hek, sat40(drive + fix_mul(c_exc, se)))
                       - 2 * fix_mul(ke, x4) - fix_mul(kee, x1));
        d.f[5] = sat40(fix_mul(hik, fix_mul(c_inh, si)) - 2 * fix_mul(ki, x5)
                       - fix_mul(kii, x2));
        d.f[6] = vp;
        return d;
    endfunction

    task automatic check_field(string nm, longint e, logic signed [39:0] a);
        if (longint'(a) != e)
        begin
            $error("%s mismatch: expected %0d, got %0d", nm, e, longint'(a));
            err_cnt++;
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Expectations are formed at the accepting edge from the current register copy.
    always @(posedge clk)
    begin
        deriv_t d;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        if (rst_n && cfg_valid && cfg_ready)
            cfg_copy[cfg_index] = longint'({25'd0, cfg_data});
        if (rst_n && item_valid && !item_stall)
        begin
            d = predict_derivs(longint'(pyr_potential), longint'(exc_potential),
                               longint'(inh_potential), longint'(pyr_aux),
                               longint'(exc_aux), longint'(inh_aux),
                               longint'(external_drive));
            if (row_has_eeg)
                d.f[6] = row_eeg;
            deriv_q.insert(deriv_q.size(), d);
            items_in++;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            results_out++;
            if (deriv_q.size() == 0)
            begin
                $error("result item arrived with no expectation pending");
                err_cnt++;
            end
            else
            begin
                d = deriv_q.pop_front();
                check_field("d_pyr_potential", d.f[0], d_pyr_potential);
                check_field("d_exc_potential", d.f[1], d_exc_potential);
                check_field("d_inh_potential", d.f[2], d_inh_potential);
                check_field("d_pyr_aux", d.f[3], d_pyr_aux);
                check_field("d_exc_aux", d.f[4], d_exc_aux);
                check_field("d_inh_aux", d.f[5], d_inh_aux);
                check_field("eeg_value", d.f[6], eeg_value);
            end
        end
    end

    always @(negedge clk)
    begin
        int r;
        if (stall_left > 0)
            stall_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                stall_lvl = 1'b0;
                stall_left = $urandom_range(1, 20);
            end
            else if (r < 95)
            begin
                stall_lvl = 1'b1;
                stall_left = $urandom_range(1, 3);
            end
            else
            begin
                stall_lvl = 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
        result_stall <= stall_lvl;
    end

    task automatic write_reg(jrd_pkg::reg_index_t idx, logic [38:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Holds one item on the bus until accepted; the task itself lowers valid when a random gap follows.
    task automatic send_item(state_row_t s);
        int g;
        pyr_potential = 40'(s.x0);
        exc_potential = 40'(s.x1);
        inh_potential = 40'(s.x2);
        pyr_aux = 40'(s.x3);
        exc_aux = 40'(s.x4);
        inh_aux = 40'(s.x5);
        external_drive = 40'(s.drive);
        row_has_eeg = s.has_eeg;
        row_eeg = s.eeg;
        item_valid = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        g = gap_len();
        if (g > 0)
        begin
            item_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic drain_pipe();
        while (deriv_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic longint pick_value(int mode);
        logic [39:0] raw;
        int r;
        raw = 40'({$urandom, $urandom});
        if (mode < 6)
            return longint'($urandom_range(0, 32'h2000_0000)) - longint'(32'h1000_0000);
        if (mode < 8)
            return longint'(signed'(raw));
        r = $urandom_range(0, 4);
        if (r == 0) return POS_MAX;
        if (r == 1) return NEG_MAX;
        if (r == 2) return 0;
        return longint'(signed'(raw));
    endfunction

    function automatic logic [38:0] pick_reg(int phase, int idx);
        logic [38:0] raw;
        raw = 39'({$urandom, $urandom});
        case (phase)
            1: return '1;
            2: return '0;
            3: return (idx == jrd_pkg::REG_STEEPNESS) ? 39'd0 : 39'(REG_RESET[idx]);
            4, 5: return 39'((longint'($urandom_range(1, 400)) * REG_RESET[idx]) / 100);
            default: return raw;
        endcase
    endfunction

    state_row_t dir_rows[$];

    initial
    begin
        state_row_t s;
        int mode;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = jrd_pkg::REG_EXC_GAIN;
        cfg_data = '0;
        item_valid = 1'b0;
        pyr_potential = '0;
        exc_potential = '0;
        inh_potential = '0;
        pyr_aux = '0;
        exc_aux = '0;
        inh_aux = '0;
        external_drive = '0;
        cfg_copy = REG_RESET;
        build_logistic();

        dir_rows = '{
            '{0, 0, 0, 0, 0, 0, 0, 1, 0},
            '{POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1, 0},
            '{NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, 1, 0},
            '{0, POS_MAX, NEG_MAX, 0, 0, 0, 0, 1, POS_MAX},
            '{0, NEG_MAX, POS_MAX, 0, 0, 0, 0, 1, NEG_MAX},
            '{ONE / 2, 6 * ONE, 0, ONE, -ONE, ONE / 4, 3 * ONE, 0, 0},
            '{ONE, 20 * ONE, -20 * ONE, 0, 0, 0, 120 * ONE, 1, 40 * ONE},
            '{-ONE, -20 * ONE, 20 * ONE, 0, 0, 0, 0, 1, -40 * ONE},
            '{5 * ONE, 6 * ONE, 6 * ONE, 0, 0, 0, ONE, 1, 0},
            '{POS_MAX, 0, 0, NEG_MAX, POS_MAX, NEG_MAX, NEG_MAX, 0, 0},
            '{NEG_MAX, 0, 0, POS_MAX, NEG_MAX, POS_MAX, POS_MAX, 0, 0},
            '{ONE / 8, 7 * ONE, ONE, ONE / 2, ONE / 2, -ONE / 2, 2 * ONE, 1, 6 * ONE},
            '{-1, 1, -1, -1, 1, -1, -1, 1, 2},
            '{6 * ONE, 5 * ONE, -ONE, 0, 0, 0, 220 * ONE, 1, 6 * ONE}
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase > 0)
            begin
                item_valid = 1'b0;
                drain_pipe();
                for (int r = 0; r < 8; r++)
                    write_reg(jrd_pkg::reg_index_t'(r), pick_reg(phase, r));
                @(negedge clk);
            end
            foreach (dir_rows[i])
                send_item(dir_rows[i]);
            for (int n = 0; n < 150; n++)
            begin
                mode = $urandom_range(0, 9);
                s.x0 = pick_value(mode);
                s.x1 = pick_value(mode);
                s.x2 = pick_value(mode);
                s.x3 = pick_value(mode);
                s.x4 = pick_value(mode);
                s.x5 = pick_value(mode);
                s.drive = pick_value(mode);
                s.has_eeg = 0;
                s.eeg = 0;
                send_item(s);
            end
        end
        item_valid = 1'b0;
        drain_pipe();
        if (deriv_q.size() != 0)
        begin
            $error("%0d expected result items never arrived", deriv_q.size());
            err_cnt++;
        end
        $display("Sent %0d state vectors over 7 register settings (reset, all ones,",
                 items_in);
        $display("all zero, zero slope, scaled and random); %0d results checked.",
                 results_out);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
